FILE: hdl/mac_pkg.sv
// ----------------------------------------------------------------------------
// mac_pkg
// Shared types and codes of the motion alarm controller: payload structs,
// configuration image, mode codes, request codes and register indexes.
// ----------------------------------------------------------------------------
package mac_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_HALF     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOSS_TICKS      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_POSITION_OFFSET = 3'd4;

    // request codes
    localparam logic [2:0] REQ_BYTE      = 3'd0;
    localparam logic [2:0] REQ_LINK_TICK = 3'd1;
    localparam logic [2:0] REQ_BLINK     = 3'd2;
    localparam logic [2:0] REQ_MINUTE    = 3'd3;
    localparam logic [2:0] REQ_FIVE_SEC  = 3'd4;
    localparam logic [2:0] REQ_ARM       = 3'd5;
    localparam logic [2:0] REQ_RESET     = 3'd6;

    // capture phases
    localparam logic [1:0] CAP_IDLE = 2'd0;
    localparam logic [1:0] CAP_REQ  = 2'd1;
    localparam logic [1:0] CAP_RUN  = 2'd2;

    // bit positions in the LED/buzzer level word
    localparam int LED_G = 0;
    localparam int LED_R = 1;
    localparam int LED_B = 2;

    typedef enum logic [2:0] {
        MODE_RECV  = 3'd0,
        MODE_DOWN  = 3'd1,
        MODE_ARMED = 3'd2,
        MODE_LOST  = 3'd3,
        MODE_ALARM = 3'd4
    } t_mode;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic        green_on;
        logic        red_on;
        logic        buzzer_on;
        logic [2:0]  mode;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
    } t_out_item;

    typedef struct packed {
        logic [9:0] window_half;
        logic [1:0] loss_ticks;
        logic [7:0] start_byte;
        logic [4:0] frame_length;
        logic [3:0] position_offset;
    } t_cfg;

endpackage

FILE: hdl/mac_cfg.sv
// ----------------------------------------------------------------------------
// mac_cfg
// Configuration register file. Takes one write per cycle; writes to indexes
// past the register list are dropped.
// ----------------------------------------------------------------------------
module mac_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mac_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [mac_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output mac_pkg::t_cfg                    o_cfg
);
    import mac_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_HALF:     n_cfg.window_half     = i_cfg_data[9:0];
                CFG_LOSS_TICKS:      n_cfg.loss_ticks      = i_cfg_data[1:0];
                CFG_START_BYTE:      n_cfg.start_byte      = i_cfg_data[7:0];
                CFG_FRAME_LENGTH:    n_cfg.frame_length    = i_cfg_data[4:0];
                CFG_POSITION_OFFSET: n_cfg.position_offset = i_cfg_data[3:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_half     <= 10'd31;
            r_cfg.loss_ticks      <= 2'd2;
            r_cfg.start_byte      <= 8'h7E;
            r_cfg.frame_length    <= 5'd19;
            r_cfg.position_offset <= 4'd12;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: hdl/mac_core.sv
// ----------------------------------------------------------------------------
// mac_core
// Controller state and its single-pass update: framer, position capture,
// window check, link supervision and LED/buzzer patterns. Produces the
// result word for the item being retired.
// ----------------------------------------------------------------------------
module mac_core #(
    parameter int POS_WIDTH = 16,
    parameter int MAX_FRAME = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  mac_pkg::t_in_item   i_item,
    input  mac_pkg::t_cfg       i_cfg,
    output mac_pkg::t_out_item  o_result
);
    import mac_pkg::*;

    localparam int AW = POS_WIDTH + 1;
    localparam int CW = AW + 10;

    t_mode                r_mode, n_mode;
    logic                 r_in_frame, n_in_frame;
    logic [4:0]           r_byte_index, n_byte_index;
    logic [7:0]           r_high, n_high;
    logic [POS_WIDTH-1:0] r_cur [3];
    logic [POS_WIDTH-1:0] n_cur [3];
    logic [POS_WIDTH-1:0] r_arm [3];
    logic [POS_WIDTH-1:0] n_arm [3];
    logic [1:0]           r_cap, n_cap;
    logic [1:0]           r_missed, n_missed;
    logic                 r_seen, n_seen;
    logic                 r_five, n_five;
    logic                 r_mwait, n_mwait;
    logic                 r_mblink, n_mblink;
    logic [1:0]           r_bcount, n_bcount;
    logic                 r_lost_beep, n_lost_beep;
    logic [2:0]           r_leds, n_leds;

    function automatic logic outside_window(
        input logic [POS_WIDTH-1:0] cur [3],
        input logic [POS_WIDTH-1:0] arm [3],
        input logic [9:0]           win
    );
        logic [AW-1:0] d;
        logic [AW-1:0] a;
        logic          hit;
        hit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            d = {1'b0, cur[k]} - {1'b0, arm[k]};
            a = d[AW-1] ? (~d + 1'b1) : d;
            if (CW'(a) >= CW'(win)) hit = 1'b1;
        end
        return hit;
    endfunction

    // next state
    always_comb begin
        logic [4:0]           len;
        logic [4:0]           rel;
        logic [1:0]           axis;
        logic [POS_WIDTH-1:0] v;
        logic                 armed_now;

        n_mode       = r_mode;
        n_in_frame   = r_in_frame;
        n_byte_index = r_byte_index;
        n_high       = r_high;
        n_cur        = r_cur;
        n_arm        = r_arm;
        n_cap        = r_cap;
        n_missed     = r_missed;
        n_seen       = r_seen;
        n_five       = r_five;
        n_mwait      = r_mwait;
        n_mblink     = r_mblink;
        n_bcount     = r_bcount;
        n_lost_beep  = r_lost_beep;
        n_leds       = r_leds;
        armed_now    = 1'b0;
        rel          = r_byte_index - {1'b0, i_cfg.position_offset};
        axis         = rel[2:1];
        v            = POS_WIDTH'({r_high, i_item.data_byte});

        len = (i_cfg.frame_length > 5'(MAX_FRAME)) ? 5'(MAX_FRAME) : i_cfg.frame_length;
        if (len == 5'd0) len = 5'd1;

        unique case (i_item.req_type)
            REQ_BYTE: begin
                if (!r_in_frame) begin
                    if (i_item.data_byte == i_cfg.start_byte) begin
                        n_in_frame   = 1'b1;
                        n_byte_index = 5'd0;
                        if (r_cap == CAP_REQ) n_cap = CAP_RUN;
                    end
                end else begin
                    if (r_byte_index >= {1'b0, i_cfg.position_offset} && rel < 5'd6) begin
                        if (!rel[0]) begin
                            n_high = i_item.data_byte;
                        end else if (r_cap == CAP_RUN) begin
                            n_arm[axis] = v;
                        end else begin
                            n_cur[axis] = v;
                        end
                    end
                    if ({1'b0, r_byte_index} + 6'd1 >= {1'b0, len}) begin
                        // frame complete
                        n_in_frame = 1'b0;
                        n_seen     = 1'b1;
                        n_missed   = 2'd0;
                        if (r_cap == CAP_RUN) begin
                            n_cap = CAP_IDLE;
                            if (r_mode == MODE_RECV) begin
                                armed_now     = 1'b1;
                                n_mode        = MODE_ARMED;
                                n_five        = 1'b1;
                                n_mwait       = 1'b1;
                                n_mblink      = 1'b0;
                                n_bcount      = 2'd0;
                                n_leds[LED_G] = 1'b1;
                            end
                        end
                        // check the positions including this byte's update
                        if (!armed_now && r_mode == MODE_ARMED &&
                            outside_window(n_cur, n_arm, i_cfg.window_half)) begin
                            n_mode        = MODE_ALARM;
                            n_leds[LED_B] = 1'b1;
                        end
                    end else begin
                        n_byte_index = r_byte_index + 5'd1;
                    end
                end
            end
            REQ_LINK_TICK: begin
                if (r_seen) begin
                    n_seen   = 1'b0;
                    n_missed = 2'd0;
                    if (r_mode == MODE_DOWN) begin
                        n_mode = MODE_RECV;
                    end else if (r_mode == MODE_LOST) begin
                        n_mode        = MODE_ARMED;
                        n_leds[LED_G] = 1'b0;
                        n_leds[LED_R] = 1'b0;
                    end
                end else begin
                    if (r_missed != 2'd3) n_missed = r_missed + 2'd1;
                    if (r_mode == MODE_DOWN) begin
                        n_missed = 2'd0;
                    end else if (n_missed >= i_cfg.loss_ticks) begin
                        if (r_mode == MODE_RECV) begin
                            n_mode   = MODE_DOWN;
                            n_missed = 2'd0;
                        end else if (r_mode == MODE_ARMED) begin
                            n_mode        = MODE_LOST;
                            n_lost_beep   = 1'b1;
                            n_leds[LED_B] = 1'b1;
                            n_missed      = 2'd0;
                        end
                    end
                end
            end
            REQ_BLINK: begin
                unique case (r_mode)
                    MODE_RECV: begin
                        n_leds[LED_G] = ~r_leds[LED_G];
                        n_leds[LED_R] = 1'b0;
                    end
                    MODE_DOWN: begin
                        n_leds[LED_R] = ~r_leds[LED_R];
                        n_leds[LED_G] = 1'b0;
                    end
                    MODE_ARMED: begin
                        if (r_mblink) begin
                            n_leds[LED_G] = ~r_leds[LED_G];
                            n_bcount      = r_bcount + 2'd1;
                        end
                        if (n_bcount == 2'd2) begin
                            n_mblink = 1'b0;
                            n_mwait  = 1'b1;
                            n_bcount = 2'd0;
                        end
                    end
                    MODE_ALARM: begin
                        n_leds[LED_G] = 1'b0;
                        n_leds[LED_R] = 1'b1;
                    end
                    MODE_LOST: begin
                        if (r_lost_beep) begin
                            n_leds[LED_B] = 1'b0;
                            n_lost_beep   = 1'b0;
                        end
                        n_leds[LED_G] = 1'b1;
                        n_leds[LED_R] = 1'b1;
                    end
                    default: n_leds = r_leds;
                endcase
            end
            REQ_MINUTE: begin
                if (r_mwait) begin
                    n_mblink = 1'b1;
                    n_mwait  = 1'b0;
                end
            end
            REQ_FIVE_SEC: begin
                if (r_five) begin
                    n_leds[LED_G] = 1'b0;
                    n_five        = 1'b0;
                end
            end
            REQ_ARM: begin
                if (r_mode == MODE_RECV && r_cap == CAP_IDLE) n_cap = CAP_REQ;
            end
            REQ_RESET: begin
                if (r_mode == MODE_ARMED || r_mode == MODE_ALARM) begin
                    n_mode        = MODE_RECV;
                    n_arm[0]      = '0;
                    n_arm[1]      = '0;
                    n_arm[2]      = '0;
                    n_five        = 1'b0;
                    n_mwait       = 1'b0;
                    n_mblink      = 1'b0;
                    n_bcount      = 2'd0;
                    n_leds[LED_B] = 1'b0;
                end
            end
            default: n_mode = r_mode;
        endcase
    end

    // result word
    always_comb begin
        o_result.green_on  = n_leds[LED_G];
        o_result.red_on    = n_leds[LED_R];
        o_result.buzzer_on = n_leds[LED_B];
        o_result.mode      = n_mode;
        o_result.pos_x     = 16'(n_cur[0]);
        o_result.pos_y     = 16'(n_cur[1]);
        o_result.pos_z     = 16'(n_cur[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_RECV;
            r_in_frame   <= 1'b0;
            r_byte_index <= 5'd0;
            r_high       <= 8'd0;
            r_cur        <= '{default: '0};
            r_arm        <= '{default: '0};
            r_cap        <= CAP_IDLE;
            r_missed     <= 2'd0;
            r_seen       <= 1'b0;
            r_five       <= 1'b0;
            r_mwait      <= 1'b0;
            r_mblink     <= 1'b0;
            r_bcount     <= 2'd0;
            r_lost_beep  <= 1'b0;
            r_leds       <= 3'd0;
        end else if (i_fire) begin
            r_mode       <= n_mode;
            r_in_frame   <= n_in_frame;
            r_byte_index <= n_byte_index;
            r_high       <= n_high;
            r_cur        <= n_cur;
            r_arm        <= n_arm;
            r_cap        <= n_cap;
            r_missed     <= n_missed;
            r_seen       <= n_seen;
            r_five       <= n_five;
            r_mwait      <= n_mwait;
            r_mblink     <= n_mblink;
            r_bcount     <= n_bcount;
            r_lost_beep  <= n_lost_beep;
            r_leds       <= n_leds;
        end
    end

    a_alarm_buzzes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_ALARM |-> r_leds[LED_B])
        else $error("alarm mode without buzzer");

    a_down_no_misses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_DOWN |-> r_missed == 2'd0)
        else $error("missed tick count held in link-down mode");

    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index < 5'(MAX_FRAME))
        else $error("byte index ran past the longest frame");

endmodule

FILE: hdl/motion_alarm_controller.sv
// ----------------------------------------------------------------------------
// motion_alarm_controller
// Path: an accepted item is held in the input register until the result
// register is free or draining, then the single-pass update retires it there.
// Throughput: one item per cycle unless the output stalls (single-pass update).
// Reset: synchronous active low; returns to receiving mode, LEDs and buzzer
// off, positions zero, configuration at its defaults. No clearing pass.
// ----------------------------------------------------------------------------
module motion_alarm_controller #(
    parameter int POS_WIDTH = 16,
    parameter int MAX_FRAME = 31
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  mac_pkg::t_in_item                i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output mac_pkg::t_out_item               o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mac_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [mac_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mac_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      w_adv;
    t_cfg      w_cfg;
    t_out_item w_result;

    // retire the held item whenever the result register is free or draining
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    mac_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    mac_core #(
        .POS_WIDTH (POS_WIDTH),
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_adv),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    a_hold_stalled_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in))
        else $error("stalled input item lost or changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with an empty result register");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("retired item produced no result");

endmodule
